### sv/pec15_pec10_frame_checker_unit_assert.svh
// assertion macros shared by the frame checker rtl
`ifndef PEC15_PEC10_FRAME_CHECKER_UNIT_ASSERT_SVH
`define PEC15_PEC10_FRAME_CHECKER_UNIT_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define PFC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("frame checker assertion failed");

// next-cycle implication, disabled while reset is asserted
`define PFC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("frame checker assertion failed");

`endif

### sv/pfc_pkg.sv
// types, constants and crc table functions of the frame checker
package pfc_pkg;

  localparam logic [15:0] Seed   = 16'd16;
  localparam logic [15:0] Poly15 = 16'h4599;
  localparam logic [9:0]  Poly10 = 10'h08f;

  typedef struct packed {
    logic [15:0] remainder;
    logic        frame_op;
    logic [1:0]  rx_high;
  } pfc_state_t;

  typedef struct packed {
    logic        valid;
    logic        frame_mode;
    logic [15:0] pec_value;
    logic        pec_match;
    logic        length_error;
  } pfc_result_t;

  // bytewise crc-15 table entry
  function automatic logic [15:0] crc15_entry(logic [7:0] idx);
    logic [15:0] r;
    r = {1'b0, idx, 7'b0};
    for (int b = 0; b < 8; b++) begin
      if (r[14]) begin
        r = {r[14:0], 1'b0} ^ Poly15;
      end else begin
        r = {r[14:0], 1'b0};
      end
    end
    return r;
  endfunction

  // n-bit shift of a crc-10 remainder, n at most 8
  function automatic logic [9:0] crc10_shift(logic [9:0] start, int unsigned steps);
    logic [9:0] r;
    r = start;
    for (int b = 0; b < 8; b++) begin
      if (b < steps) begin
        if (r[9]) begin
          r = {r[8:0], 1'b0} ^ Poly10;
        end else begin
          r = {r[8:0], 1'b0};
        end
      end
    end
    return r;
  endfunction

endpackage

### sv/pfc_step.sv
// next-state and result logic for one byte of a frame
module pfc_step import pfc_pkg::*; #(
  parameter int unsigned RESPONSE_DATA_BYTES = 6,
  parameter int unsigned PosW = 3
) (
  input  pfc_state_t          state_i,
  input  logic [PosW-1:0]     pos_i,
  input  logic                op_i,
  input  logic [7:0]          data_byte_i,
  input  logic                last_byte_i,
  output pfc_state_t          state_o,
  output logic [PosW-1:0]     pos_o,
  output pfc_result_t         result_o
);

  localparam logic [PosW-1:0] DataBytes = PosW'(RESPONSE_DATA_BYTES);
  localparam logic [PosW-1:0] FinalPos  = PosW'(RESPONSE_DATA_BYTES + 1);

  logic        first;
  logic        op_eff;
  logic [15:0] rem_eff;
  logic [15:0] rem15;
  logic [9:0]  rem10;
  logic [9:0]  fold10;
  logic [9:0]  rx_pec;
  pfc_state_t  cleared;

  assign first   = (pos_i == '0);
  assign op_eff  = first ? op_i : state_i.frame_op;
  assign rem_eff = first ? Seed : state_i.remainder;

  assign rem15  = {rem_eff[7:0], 8'b0} ^ crc15_entry(rem_eff[14:7] ^ data_byte_i);
  assign rem10  = {rem_eff[1:0], 8'b0} ^ crc10_shift({rem_eff[9:2] ^ data_byte_i, 2'b0}, 8);
  assign fold10 = crc10_shift(rem_eff[9:0] ^ {data_byte_i[7:2], 4'b0}, 6);
  assign rx_pec = {state_i.rx_high, data_byte_i};

  assign cleared = '{remainder: Seed, frame_op: 1'b0, rx_high: 2'b0};

  always_comb begin
    state_o  = state_i;
    pos_o    = pos_i;
    result_o = '0;
    if (!op_eff) begin
      if (last_byte_i) begin
        result_o.valid     = 1'b1;
        result_o.pec_value = {rem15[14:0], 1'b0};
        state_o            = cleared;
        pos_o              = '0;
      end else begin
        state_o = '{remainder: rem15, frame_op: 1'b0, rx_high: state_i.rx_high};
        pos_o   = PosW'(1);
      end
    end else if (pos_i < FinalPos && last_byte_i) begin
      // early end of a response
      result_o.valid        = 1'b1;
      result_o.frame_mode   = 1'b1;
      result_o.length_error = 1'b1;
      state_o               = cleared;
      pos_o                 = '0;
    end else if (pos_i < DataBytes) begin
      state_o = '{remainder: {6'b0, rem10}, frame_op: 1'b1, rx_high: state_i.rx_high};
      pos_o   = pos_i + PosW'(1);
    end else if (pos_i == DataBytes) begin
      state_o = '{remainder: {6'b0, fold10}, frame_op: 1'b1, rx_high: data_byte_i[1:0]};
      pos_o   = pos_i + PosW'(1);
    end else begin
      result_o.valid      = 1'b1;
      result_o.frame_mode = 1'b1;
      result_o.pec_value  = {6'b0, rem_eff[9:0]};
      result_o.pec_match  = (rx_pec == rem_eff[9:0]);
      state_o             = cleared;
      pos_o               = '0;
    end
  end

endmodule

### sv/pec15_pec10_frame_checker_unit.sv
// top level of the pec15 generator and pec10 response checker
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+----------------------------------------
//   in      | request   | in_valid_i / in_ready_o | op_i, data_byte_i, last_byte_i
//   out     | result    | out_valid_o/out_ready_i | frame_mode_o, pec_value_o,
//           |           |                         | pec_match_o, length_error_o
//
// one byte per cycle sustained while the result is not stalled; a byte is held in
// the input register, then passes the bytewise crc step into the result register
// the crc step feeds the running remainder back through the frame state
// register, so that loop sets the rate
// reset clears the frame state (remainder to seed 16) and both valid flags
// a stalled result blocks only the input register, which still takes a request
// while it is empty
`include "pec15_pec10_frame_checker_unit_assert.svh"

module pec15_pec10_frame_checker_unit import pfc_pkg::*; #(
  parameter int unsigned RESPONSE_DATA_BYTES = 6
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        op_i,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        frame_mode_o,
  output logic [15:0] pec_value_o,
  output logic        pec_match_o,
  output logic        length_error_o
);

  // position runs 0 .. data bytes + 1
  localparam int unsigned PosW = $clog2(RESPONSE_DATA_BYTES + 2);
  localparam logic [PosW-1:0] FinalPos = PosW'(RESPONSE_DATA_BYTES + 1);

  // input register
  logic       in_vq;
  logic       op_q;
  logic [7:0] byte_q;
  logic       last_q;

  // frame state
  pfc_state_t      state_q, state_d;
  logic [PosW-1:0] pos_q, pos_d;

  // result register
  logic        out_vq;
  pfc_result_t res_d;
  logic        mode_q;
  logic [15:0] pec_q;
  logic        match_q;
  logic        lerr_q;

  logic advance;

  // the buffered byte moves on once the result slot is free or draining
  assign advance    = in_vq && (!out_vq || out_ready_i);
  assign in_ready_o = !in_vq || advance;

  pfc_step #(
    .RESPONSE_DATA_BYTES(RESPONSE_DATA_BYTES),
    .PosW               (PosW)
  ) u_step (
    .state_i    (state_q),
    .pos_i      (pos_q),
    .op_i       (op_q),
    .data_byte_i(byte_q),
    .last_byte_i(last_q),
    .state_o    (state_d),
    .pos_o      (pos_d),
    .result_o   (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vq   <= 1'b0;
      out_vq  <= 1'b0;
      state_q <= '{remainder: Seed, frame_op: 1'b0, rx_high: 2'b0};
      pos_q   <= '0;
    end else begin
      if (in_ready_o) begin
        in_vq <= in_valid_i;
      end
      if (advance) begin
        state_q <= state_d;
        pos_q   <= pos_d;
      end
      if (advance && res_d.valid) begin
        out_vq <= 1'b1;
      end else if (out_ready_i) begin
        out_vq <= 1'b0;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      op_q   <= op_i;
      byte_q <= data_byte_i;
      last_q <= last_byte_i;
    end
    if (advance && res_d.valid) begin
      mode_q  <= res_d.frame_mode;
      pec_q   <= res_d.pec_value;
      match_q <= res_d.pec_match;
      lerr_q  <= res_d.length_error;
    end
  end

  assign out_valid_o    = out_vq;
  assign frame_mode_o   = mode_q;
  assign pec_value_o    = pec_q;
  assign pec_match_o    = match_q;
  assign length_error_o = lerr_q;

  // a response result carries only ten pec bits
  `PFC_ASSERT_NOW(a_pec10_narrow, clk_i, rst_ni,
    out_vq && mode_q, pec_q[15:10] == 6'b0)
  // a generate result never flags a match or a length error
  `PFC_ASSERT_NOW(a_gen_flags, clk_i, rst_ni,
    out_vq && !mode_q, !match_q && !lerr_q)
  // a length error comes with a zero pec and no match
  `PFC_ASSERT_NOW(a_lerr_clean, clk_i, rst_ni,
    out_vq && lerr_q, mode_q && !match_q && pec_q == 16'h0)
  // position never passes the final pec byte
  `PFC_ASSERT_NOW(a_pos_bound, clk_i, rst_ni, 1'b1, pos_q <= FinalPos)
  // input is held off only behind a stalled result
  `PFC_ASSERT_NOW(a_stall_cause, clk_i, rst_ni,
    !in_ready_o, in_vq && out_vq && !out_ready_i)
  // a finished frame leaves the position at zero
  `PFC_ASSERT_NEXT(a_frame_end, clk_i, rst_ni,
    advance && res_d.valid, pos_q == '0)

endmodule
